@@ src/csb_pkg.sv @@
// Shared types and codes for the byte sequence buffer.
`default_nettype none
package csb_pkg;
    typedef enum logic [3:0] {
        ACT_APPEND   = 4'd0,
        ACT_PREPEND  = 4'd1,
        ACT_INSERT   = 4'd2,
        ACT_RMFIRST  = 4'd3,
        ACT_RMLAST   = 4'd4,
        ACT_RMAT     = 4'd5,
        ACT_GET      = 4'd6,
        ACT_SET      = 4'd7,
        ACT_FINDFST  = 4'd8,
        ACT_FINDLST  = 4'd9,
        ACT_CLEAR    = 4'd10
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [4:0] NOT_FOUND = 5'h1F;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_EXEC = 2'd1,
        CS_SCAN = 2'd2,
        CS_DONE = 2'd3
    } ctrl_state_t;

    // datapath operation commanded by the controller
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_OPEN  = 3'd1,
        OP_CLOSE = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_CLEAR = 3'd5,
        OP_DEC   = 3'd6
    } dp_op_t;

    typedef struct packed {
        logic   load;      // capture the incoming item
        logic   exec;      // carry out the captured command
        logic   scan_step; // advance the search by one element
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_stat_t;
endpackage
`default_nettype wire

@@ src/csb_datapath.sv @@
// Datapath: cell array, count, search scanner and result register.
`default_nettype none
module csb_datapath #(
    parameter int DEPTH = 16,
    parameter int CW = ($clog2(DEPTH + 1) > 5) ? $clog2(DEPTH + 1) : 5,
    parameter int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire csb_pkg::dp_cmd_t cmd,
    output csb_pkg::dp_stat_t    stat,
    input  wire logic [3:0]      action_in,
    input  wire logic [3:0]      position_in,
    input  wire logic [7:0]      byte_in,
    output csb_pkg::action_t     act_cur,
    output logic                 err_range,
    output logic                 err_full,
    output logic [7:0]           byte_out,
    output logic [4:0]           found_at,
    output logic [1:0]           status,
    output logic [4:0]           length
);
    import csb_pkg::*;

    logic [7:0]    cell_reg [DEPTH];
    logic [7:0]    cell_next [DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    act_reg;
    logic [3:0]    pos_reg;
    logic [7:0]    byte_reg;
    logic [CW-1:0] scan_reg, scan_next;  // elements left to examine
    logic [4:0]    found_reg, found_next;
    logic [7:0]    bout_reg, bout_next;
    logic [1:0]    stat_reg, stat_next;
    logic          full, empty, pos_bad;
    logic [CW-1:0] pos_ext, at;
    logic [CW-1:0] probe;
    logic [PW-1:0] probe_idx;
    logic          hit;

    assign act_cur = action_t'(act_reg);
    assign full    = (count_reg >= CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CW'(pos_reg);
    assign pos_bad = (pos_ext >= count_reg);
    assign err_range = ((act_cur == ACT_INSERT || act_cur == ACT_RMAT || act_cur == ACT_GET
                         || act_cur == ACT_SET) && pos_bad)
                     || ((act_cur == ACT_RMFIRST || act_cur == ACT_RMLAST) && empty);
    assign err_full = full;

    // insertion / removal point
    always_comb begin
        unique case (act_cur)
            ACT_APPEND:  at = count_reg;
            ACT_PREPEND, ACT_RMFIRST: at = '0;
            default:     at = pos_ext;
        endcase
    end

    // search probe: forward from the head or backward from the tail
    always_comb begin
        if (act_cur == ACT_FINDFST) probe = count_reg - scan_reg;
        else                        probe = scan_reg - CW'(1);
        probe_idx = probe[PW-1:0];
        hit = (scan_reg != '0) && (cell_reg[probe_idx] == byte_reg);
    end
    assign stat.scan_done = (scan_reg == '0) || hit;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) cell_next[i] = cell_reg[i];
        count_next = count_reg;
        found_next = found_reg;
        bout_next  = bout_reg;
        stat_next  = stat_reg;
        scan_next  = scan_reg;
        if (cmd.load) begin
            found_next = NOT_FOUND;
            bout_next  = '0;
            stat_next  = ST_OK;
            scan_next  = count_reg;
        end
        if (cmd.exec) begin
            if (err_range)                   stat_next = ST_RANGE;
            else if (cmd.op == OP_NONE && full) stat_next = ST_FULL;
            unique case (cmd.op)
                OP_OPEN: begin
                    for (int i = 1; i < DEPTH; i++)
                        if (CW'(i) > at && CW'(i) <= count_reg) cell_next[i] = cell_reg[i-1];
                    for (int i = 0; i < DEPTH; i++)
                        if (CW'(i) == at) cell_next[i] = byte_reg;
                    count_next = count_reg + CW'(1);
                end
                OP_CLOSE: begin
                    for (int i = 0; i < DEPTH - 1; i++)
                        if (CW'(i) >= at) cell_next[i] = cell_reg[i+1];
                    count_next = count_reg - CW'(1);
                end
                OP_DEC:   count_next = count_reg - CW'(1);
                OP_WRITE: cell_next[pos_ext[PW-1:0]] = byte_reg;
                OP_READ:  bout_next = cell_reg[pos_ext[PW-1:0]];
                OP_CLEAR: count_next = '0;
                default: ;
            endcase
        end
        if (cmd.scan_step) begin
            if (hit)                 found_next = probe[4:0];
            else if (scan_reg != '0) scan_next = scan_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) cell_reg[i] <= cell_next[i];
        found_reg <= found_next;
        bout_reg  <= bout_next;
        stat_reg  <= stat_next;
        scan_reg  <= scan_next;
        if (cmd.load) begin
            act_reg  <= action_in;
            pos_reg  <= position_in;
            byte_reg <= byte_in;
        end
        if (!aresetn) count_reg <= '0;
        else          count_reg <= count_next;
    end

    assign byte_out = bout_reg;
    assign found_at = found_reg;
    assign status   = stat_reg;
    assign length   = count_reg[4:0];
endmodule
`default_nettype wire

@@ src/csb_ctrl.sv @@
// Controller state machine sequencing each command.
`default_nettype none
module csb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire csb_pkg::action_t  act_cur,
    input  wire logic              err_range,
    input  wire logic              err_full,
    input  wire csb_pkg::dp_stat_t stat,
    output csb_pkg::dp_cmd_t       cmd
);
    import csb_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: if (s_valid) state_next = CS_EXEC;
            CS_EXEC: begin
                if (act_cur == ACT_FINDFST || act_cur == ACT_FINDLST) state_next = CS_SCAN;
                else state_next = CS_DONE;
            end
            CS_SCAN: if (stat.scan_done) state_next = CS_DONE;
            CS_DONE: if (m_ready) state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        cmd = '{load: 1'b0, exec: 1'b0, scan_step: 1'b0, op: OP_NONE};
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            CS_EXEC: begin
                cmd.exec = 1'b1;
                if (!err_range) begin
                    unique case (act_cur)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT:
                            cmd.op = err_full ? OP_NONE : OP_OPEN;
                        ACT_RMFIRST, ACT_RMAT: cmd.op = OP_CLOSE;
                        ACT_RMLAST: cmd.op = OP_DEC;
                        ACT_GET:    cmd.op = OP_READ;
                        ACT_SET:    cmd.op = OP_WRITE;
                        ACT_CLEAR:  cmd.op = OP_CLEAR;
                        default:    cmd.op = OP_NONE;
                    endcase
                end
                // only open-type commands report full; mask others
                if (!(act_cur == ACT_APPEND || act_cur == ACT_PREPEND
                      || act_cur == ACT_INSERT) && cmd.op == OP_NONE)
                    cmd.exec = err_range;
            end
            CS_SCAN: cmd.scan_step = 1'b1;
            CS_DONE: m_valid = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= CS_IDLE;
        else          state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ src/char_sequence_buffer.sv @@
// Top level of the indexed byte sequence buffer.
//
// Usage: commands arrive on the s_axis stream, one item each, carrying
// action, position and the byte to store or search for. Every command
// produces exactly one result item on the m_axis stream: byte read,
// position found (-1 when absent or not a search), status and count.
//
// Timing: a command is taken, executed in the following cycle, and its
// result is then held in the output register until taken. A search
// examines one stored byte per cycle through a single comparator and
// stops at the first match, or once every stored byte has been examined
// when nothing matches. One item is in flight at a time; s_tready is low
// until the result of the previous item has been taken.
//
// Reset (aresetn low, synchronous) empties the store and drops any
// command in progress. The stored bytes themselves are not cleared.
// When the receiver stalls, the result holds steady on m_axis_tdata.
`default_nettype none
module char_sequence_buffer #(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // action[3:0], position[7:4], byte_in[15:8]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // byte_out[7:0], found_at[12:8],
                                            // status[14:13], length[19:15], zero[23:20]
);
    import csb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    action_t  act_cur;
    logic     err_range, err_full;
    logic [7:0] byte_out;
    logic [4:0] found_at, length;
    logic [1:0] status;

    csb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .act_cur(act_cur), .err_range(err_range), .err_full(err_full),
        .stat(stat), .cmd(cmd)
    );

    csb_datapath #(.DEPTH(DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .action_in(s_axis_tdata[3:0]), .position_in(s_axis_tdata[7:4]),
        .byte_in(s_axis_tdata[15:8]),
        .act_cur(act_cur), .err_range(err_range), .err_full(err_full),
        .byte_out(byte_out), .found_at(found_at), .status(status), .length(length)
    );

    assign m_axis_tdata = {4'd0, length, status, found_at, byte_out};

    // never accept a new item while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output open together");

    // a result is never presented directly after an accepted item
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");

    // an error status (range or full) never reports a byte
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && status != ST_OK) |-> (byte_out == 8'd0))
        else $error("byte reported on error");
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the indexed byte sequence buffer.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps its own copy of the stored bytes and count, works out the
// result of each accepted command and compares it with the result stream.
class deque_scoreboard;
    logic [7:0]  shadow_bytes [16];
    int unsigned shadow_count;
    logic [23:0] pending_results [$];
    int unsigned error_count;

    function void clear_state();
        shadow_count = 0;
        pending_results.delete();
        error_count = 0;
        foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
    endfunction

    // Apply one accepted command and queue the result it must give.
    function void note_command(logic [15:0] cmd);
        logic [3:0]  act;
        int unsigned pos;
        logic [7:0]  val;
        logic [7:0]  rd;
        logic [4:0]  hit;
        logic [1:0]  st;
        bit          is_full;
        int          i;
        act = cmd[3:0];
        pos = cmd[7:4];
        val = cmd[15:8];
        rd = 8'h00;
        hit = csb_pkg::NOT_FOUND;
        st = csb_pkg::ST_OK;
        is_full = (shadow_count >= 16);
        case (act)
            csb_pkg::ACT_APPEND: begin
                if (is_full) st = csb_pkg::ST_FULL;
                else open_slot(shadow_count, val);
            end
            csb_pkg::ACT_PREPEND: begin
                if (is_full) st = csb_pkg::ST_FULL;
                else open_slot(0, val);
            end
            csb_pkg::ACT_INSERT: begin
                if (pos >= shadow_count) st = csb_pkg::ST_RANGE;
                else if (is_full) st = csb_pkg::ST_FULL;
                else open_slot(pos, val);
            end
            csb_pkg::ACT_RMFIRST: begin
                if (shadow_count == 0) st = csb_pkg::ST_RANGE;
                else close_slot(0);
            end
            csb_pkg::ACT_RMLAST: begin
                if (shadow_count == 0) st = csb_pkg::ST_RANGE;
                else shadow_count--;
            end
            csb_pkg::ACT_RMAT: begin
                if (pos >= shadow_count) st = csb_pkg::ST_RANGE;
                else close_slot(pos);
            end
            csb_pkg::ACT_GET: begin
                if (pos >= shadow_count) st = csb_pkg::ST_RANGE;
                else rd = shadow_bytes[pos];
            end
            csb_pkg::ACT_SET: begin
                if (pos >= shadow_count) st = csb_pkg::ST_RANGE;
                else shadow_bytes[pos] = val;
            end
            csb_pkg::ACT_FINDFST: begin
                for (i = int'(shadow_count) - 1; i >= 0; i--)
                    if (shadow_bytes[i] == val) hit = i[4:0];
            end
            csb_pkg::ACT_FINDLST: begin
                for (i = 0; i < int'(shadow_count); i++)
                    if (shadow_bytes[i] == val) hit = i[4:0];
            end
            csb_pkg::ACT_CLEAR: shadow_count = 0;
            default: ;
        endcase
        pending_results.insert(pending_results.size(),
                               {4'h0, shadow_count[4:0], st, hit, rd});
    endfunction

    function void open_slot(int unsigned at, logic [7:0] val);
        for (int unsigned i = shadow_count; i > at; i--)
            shadow_bytes[i] = shadow_bytes[i - 1];
        shadow_bytes[at] = val;
        shadow_count++;
    endfunction

    function void close_slot(int unsigned at);
        for (int unsigned i = at; i + 1 < shadow_count; i++)
            shadow_bytes[i] = shadow_bytes[i + 1];
        shadow_count--;
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [23:0] res);
        logic [23:0] want;
        if (pending_results.size() == 0) begin
            report("unexpected result", res, 0);
            return;
        end
        want = pending_results.pop_front();
        if (res[7:0] !== want[7:0])     report("byte_out", res[7:0], want[7:0]);
        if (res[12:8] !== want[12:8])   report("found_at", res[12:8], want[12:8]);
        if (res[14:13] !== want[14:13]) report("status", res[14:13], want[14:13]);
        if (res[19:15] !== want[19:15]) report("length", res[19:15], want[19:15]);
        if (res[23:20] !== 4'h0)        report("padding", res[23:20], 0);
    endfunction
endclass

module testbench;
    import csb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // action[3:0], position[7:4], byte_in[15:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // byte_out[7:0], found_at[12:8], status[14:13],
                                 // length[19:15], zero[23:20]

    deque_scoreboard board;
    bit              ready_pattern;   // set: receiver holds tready high throughout

    char_sequence_buffer #(.DEPTH(16)) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one command and hold it until the block takes it; drop valid
    // only across an idle gap. Entered and left at a falling edge.
    task automatic send_command(logic [3:0] act, logic [3:0] pos, logic [7:0] val,
                                bit idle_first);
        int unsigned gap;
        gap = idle_first ? gap_length() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= {val, pos, act};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_command({val, pos, act});
        @(negedge aclk);
    endtask

    // Pick a command, steering positions mostly inside the current length.
    task automatic send_random(bit idle_first);
        logic [3:0]  act;
        logic [3:0]  pos;
        logic [7:0]  val;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 22)      act = ACT_APPEND;
        else if (roll < 32) act = ACT_PREPEND;
        else if (roll < 44) act = ACT_INSERT;
        else if (roll < 94) act = 4'($urandom_range(3, 9));
        else if (roll < 97) act = ACT_CLEAR;
        else                act = 4'($urandom_range(11, 15));
        if (board.shadow_count > 0 && $urandom_range(0, 9) < 8)
            pos = 4'($urandom_range(0, board.shadow_count - 1));
        else
            pos = 4'($urandom);
        // Small alphabet so searches hit often; full range otherwise.
        if ($urandom_range(0, 1)) val = 8'($urandom_range(0, 3)) | 8'hA0;
        else                      val = 8'($urandom);
        send_command(act, pos, val, idle_first);
    endtask

    // Receiver: random back-pressure, or tready held high while ready_pattern is set, checking every accepted result.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_pattern) m_axis_tready <= 1'b1;
            else               m_axis_tready <= ($urandom_range(0, 99) < 60);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // Stimulus and end of run.
    initial begin
        int unsigned wait_cycles;
        board = new();
        board.clear_state();
        ready_pattern = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-store errors, fill to full, overflow, edges.
        send_command(ACT_RMFIRST, 4'd0, 8'h00, 1'b0);
        send_command(ACT_RMLAST, 4'd0, 8'h00, 1'b0);
        send_command(ACT_FINDFST, 4'd0, 8'h00, 1'b0);
        send_command(ACT_GET, 4'd0, 8'h00, 1'b0);
        send_command(ACT_INSERT, 4'd0, 8'h11, 1'b0);
        for (int k = 0; k < 16; k++)
            send_command(ACT_APPEND, 4'(k), (k[0] ? 8'hFF : 8'h00), 1'b0);
        send_command(ACT_PREPEND, 4'd0, 8'h55, 1'b0);
        send_command(ACT_INSERT, 4'd15, 8'hAA, 1'b0);
        send_command(ACT_SET, 4'd15, 8'h7E, 1'b0);
        send_command(ACT_GET, 4'd15, 8'h00, 1'b0);
        send_command(ACT_FINDLST, 4'd0, 8'hFF, 1'b0);
        send_command(ACT_RMAT, 4'd15, 8'h00, 1'b0);
        send_command(ACT_INSERT, 4'd15, 8'h81, 1'b0);
        send_command(4'd15, 4'd15, 8'hFF, 1'b0);
        send_command(ACT_CLEAR, 4'd0, 8'h00, 1'b0);

        // Random: alternate bursts that may idle before any command and bursts that idle rarely.
        for (int n = 0; n < 900; n++) begin
            if (n % 150 == 0) ready_pattern = (n % 300 == 0);
            send_random((n % 300) >= 150 || n % 7 == 0);
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (board.pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (40) @(posedge aclk);
        if (board.error_count == 0 && board.pending_results.size() == 0)
            $display("char_sequence_buffer verification clean");
        else
            $display("char_sequence_buffer verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("char_sequence_buffer verification failed");
        $finish;
    end
endmodule

`default_nettype wire
